>>> sv/mis_pkg.sv
// Shared types and constants for the maximal independent set status block.
// No dependencies; imported by mis_ctrl, mis_dp and the top level.
`default_nettype none

package mis_pkg;

    localparam int VERTEX_W = 16;

    typedef enum logic [1:0] {
        ST_UNDECIDED = 2'd0,
        ST_COND_IN   = 2'd1,
        ST_OUT       = 2'd2,
        ST_IN        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_FILTER = 2'd1,
        CMD_INIT   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_wr;
        logic rd_en;
        logic exec;
    } mis_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic res_full;
    } mis_stat_t;

endpackage

`default_nettype wire

>>> sv/mis_ctrl.sv
// Controller for the status block: clearing pass, request accept, update step.
// Depends on mis_pkg.
`default_nettype none

module mis_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic              res_ready,
    input  wire mis_pkg::mis_stat_t stat,
    output mis_pkg::mis_cmd_t      ctl
);
    import mis_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_ready    = 1'b0;
        ctl.clear_wr = 1'b0;
        ctl.rd_en    = 1'b0;
        ctl.exec     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.rd_en = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the update until the result register has room
                if (!stat.res_full || res_ready)
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/mis_dp.sv
// Datapath: status memory, request registers, update logic and result register.
// Depends on mis_pkg; driven by mis_ctrl.
`default_nettype none

module mis_dp #(
    parameter int MAX_VERTICES = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mis_pkg::mis_cmd_t             ctl,
    output mis_pkg::mis_stat_t                 stat,
    input  wire logic [1:0]                    command,
    input  wire logic [mis_pkg::VERTEX_W-1:0]  source_vertex,
    input  wire logic [mis_pkg::VERTEX_W-1:0]  dest_vertex,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [mis_pkg::VERTEX_W-1:0]       vertex,
    output logic [1:0]                         new_status,
    output logic                               next_round
);
    import mis_pkg::*;

    localparam int VSPAN = 1 << VERTEX_W;
    localparam int DEPTH = (MAX_VERTICES > VSPAN) ? VSPAN : MAX_VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0] mem [DEPTH];

    logic [AW-1:0]       clear_cnt_reg;
    logic [1:0]          cmd_reg;
    logic [VERTEX_W-1:0] src_reg;
    logic [VERTEX_W-1:0] dst_reg;
    logic [1:0]          rd_src_reg;
    logic [1:0]          rd_dst_reg;

    logic                res_valid_reg;
    logic [VERTEX_W-1:0] vertex_reg;
    logic [1:0]          status_reg;
    logic                next_reg;

    logic    src_ok;
    logic    dst_ok;
    status_t src_st;
    status_t dst_st;
    status_t st_next;
    logic    nr_next;
    logic    wr_en;

    assign stat.clear_last = (clear_cnt_reg == AW'(DEPTH - 1));
    assign stat.res_full   = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (ctl.clear_wr)
        begin
            clear_cnt_reg <= clear_cnt_reg + AW'(1);
        end
    end

    // Memory: clearing pass or update on the write port, two registered reads.
    always_ff @(posedge clk)
    begin
        if (ctl.clear_wr)
        begin
            mem[clear_cnt_reg] <= ST_COND_IN;
        end
        else if (ctl.exec && wr_en)
        begin
            mem[src_reg[AW-1:0]] <= st_next;
        end
        if (ctl.rd_en)
        begin
            rd_src_reg <= mem[source_vertex[AW-1:0]];
            rd_dst_reg <= mem[dest_vertex[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            cmd_reg <= command;
            src_reg <= source_vertex;
            dst_reg <= dest_vertex;
        end
    end

    always_comb
    begin
        src_ok  = 32'(src_reg) < 32'(MAX_VERTICES);
        dst_ok  = 32'(dst_reg) < 32'(MAX_VERTICES);
        src_st  = src_ok ? status_t'(rd_src_reg) : ST_UNDECIDED;
        dst_st  = status_t'(rd_dst_reg);
        st_next = src_st;
        nr_next = 1'b0;
        wr_en   = 1'b0;
        if (src_ok)
        begin
            case (cmd_t'(cmd_reg))
                CMD_EDGE:
                begin
                    if (dst_ok)
                    begin
                        wr_en = 1'b1;
                        if (dst_st == ST_IN)
                        begin
                            st_next = ST_OUT;
                        end
                        else if ((dst_reg < src_reg) && (src_st == ST_COND_IN) &&
                                 ((dst_st == ST_UNDECIDED) || (dst_st == ST_COND_IN)))
                        begin
                            // a higher-priority neighbour is still open: back off
                            st_next = ST_UNDECIDED;
                        end
                    end
                end
                CMD_FILTER:
                begin
                    wr_en = 1'b1;
                    if (src_st == ST_COND_IN)
                    begin
                        st_next = ST_IN;
                    end
                    else if (src_st != ST_OUT)
                    begin
                        st_next = ST_COND_IN;
                        nr_next = 1'b1;
                    end
                end
                CMD_INIT:
                begin
                    wr_en   = 1'b1;
                    st_next = ST_COND_IN;
                    nr_next = 1'b1;
                end
                default:
                begin
                    // unused code: report the current status, leave the store alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            vertex_reg <= src_reg;
            status_reg <= st_next;
            next_reg   <= nr_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign vertex     = vertex_reg;
    assign new_status = status_reg;
    assign next_round = next_reg;

endmodule

`default_nettype wire

>>> sv/maximal_independent_set_flags.sv
// Top level of the maximal independent set status block.
// Depends on mis_pkg, mis_ctrl and mis_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  cmd     | cmd_valid/cmd_ready  | command, source_vertex, dest_vertex
//  res     | res_valid/res_ready  | vertex, new_status, next_round
//
// Each request goes through a registered read of the status memory (source and
// destination ports), then the update and write-back, held while a result waits.
// After reset a clearing pass writes one entry a cycle over min(MAX_VERTICES,
// 65536) entries (65536 by default); cmd_ready stays low throughout.
// A request may be accepted while a result waits; its update holds until the
// result register is taken.
`default_nettype none

module maximal_independent_set_flags #(
    parameter int MAX_VERTICES = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire logic [1:0]                   command,
    input  wire logic [mis_pkg::VERTEX_W-1:0] source_vertex,
    input  wire logic [mis_pkg::VERTEX_W-1:0] dest_vertex,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [mis_pkg::VERTEX_W-1:0]      vertex,
    output logic [1:0]                        new_status,
    output logic                              next_round
);
    import mis_pkg::*;

    mis_cmd_t  ctl;
    mis_stat_t stat;

    mis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_ready (res_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    mis_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .command       (command),
        .source_vertex (source_vertex),
        .dest_vertex   (dest_vertex),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .vertex        (vertex),
        .new_status    (new_status),
        .next_round    (next_round)
    );

`ifndef SYNTH
    // one request in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("request accepted while previous one in flight");

    // no request taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear_wr |-> !cmd_ready)
        else $error("request accepted during clearing pass");

    // an update always yields a visible result next cycle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> res_valid)
        else $error("update gave no result");
`endif

endmodule

`default_nettype wire
